// ===== rtl/qowm_pkg.sv =====
// Shared types and constants of the queue occupancy and wait monitor.
`timescale 1ns / 1ps

package qowm_pkg;

  // Default parameter values.
  localparam int TIME_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 32;

  // Fixed datapath widths.
  localparam int AREA_BITS = 64;
  localparam int DEN_BITS  = 48;
  localparam int MEAN_BITS = 48;
  localparam int ALU_BITS  = 64;

  // Event kinds.
  localparam logic [1:0] OP_ARRIVE = 2'd0;
  localparam logic [1:0] OP_DEPART = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_BACKWARD = 2'd2;

  // Request to the shared adder/subtractor.
  typedef struct packed {
    logic [ALU_BITS-1:0] a;
    logic [ALU_BITS-1:0] b;
    logic                sub;
  } alu_req_t;

endpackage

// ===== rtl/qowm_in_if.sv =====
// Event channel interface of the queue occupancy and wait monitor.
`timescale 1ns / 1ps

interface qowm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] event_time;

  modport source (output valid, output op, output event_time, input ready);
  modport sink   (input valid, input op, input event_time, output ready);
endinterface

// ===== rtl/qowm_out_if.sv =====
// Result channel interface of the queue occupancy and wait monitor.
`timescale 1ns / 1ps

interface qowm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] queue_length;
  logic [31:0] max_queue_length;
  logic [47:0] mean_occupancy;
  logic [47:0] mean_wait;
  logic [1:0]  status;

  modport source (output valid, output queue_length, output max_queue_length,
                  output mean_occupancy, output mean_wait, output status,
                  input ready);
  modport sink   (input valid, input queue_length, input max_queue_length,
                  input mean_occupancy, input mean_wait, input status,
                  output ready);
endinterface

// ===== rtl/qowm_alu.sv =====
// Shared 64-bit adder/subtractor with carry or borrow out.
`timescale 1ns / 1ps

module qowm_alu (
  input  qowm_pkg::alu_req_t             req,
  output logic [qowm_pkg::ALU_BITS:0]    res
);

  // Bit ALU_BITS is the carry on add and the borrow on subtract.
  always_comb begin
    if (req.sub) begin
      res = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      res = {1'b0, req.a} + {1'b0, req.b};
    end
  end

endmodule

// ===== rtl/queue_occupancy_wait_monitor_top.sv =====
// Top level of the queue occupancy and wait monitor: sequencer, state and result register.
`timescale 1ns / 1ps

// Accepts one arrival, departure or report beat at a time and answers each with one
// result beat. All arithmetic runs through a single 64-bit adder/subtractor under a
// small sequencer, and in_ready is low from acceptance until the result is loaded.
// An ignored event (backward time, departure on an empty queue, unused op) goes
// straight to the result. Any other event updates the three areas by elapsed time
// times each of the three counts (items in system, arrivals, departures), by
// shift-and-add one multiplier bit per cycle, stopping when the multiplier is spent.
// A report then adds two divisions of 48 restoring steps each, unless one ends early.
// The next event is accepted while a finished result still waits on out_chan.

module queue_occupancy_wait_monitor_top #(
  parameter int TIME_BITS  = qowm_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = qowm_pkg::COUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  qowm_in_if.sink        in_chan,
  qowm_out_if.source     out_chan
);

  localparam int AW = qowm_pkg::AREA_BITS;
  localparam int DW = qowm_pkg::DEN_BITS;
  localparam int MW = qowm_pkg::MEAN_BITS;
  localparam int SW = $clog2(DW);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_DIFF  = 3'd4;
  localparam logic [2:0] S_DCHK  = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [MW-1:0]         MEAN_MAX = '1;
  localparam logic [SW-1:0]         LAST_STEP = SW'(DW - 1);

  logic [2:0]              state_r;
  logic [1:0]              op_r;
  logic [TIME_BITS-1:0]    t_r;
  logic [TIME_BITS-1:0]    prev_time_r;
  logic [TIME_BITS-1:0]    dt_r;
  logic [COUNT_BITS-1:0]   items_r;
  logic [COUNT_BITS-1:0]   largest_r;
  logic [COUNT_BITS-1:0]   arrivals_r;
  logic [COUNT_BITS-1:0]   departures_r;
  logic [AW-1:0]           occ_area_r;
  logic [AW-1:0]           arr_area_r;
  logic [AW-1:0]           dep_area_r;

  // Multiply-accumulate working registers.
  logic [1:0]              idx_r;
  logic [AW-1:0]           acc_r;
  logic                    acc_sat_r;
  logic [AW-1:0]           mcand_r;
  logic                    mcand_ovf_r;
  logic [COUNT_BITS-1:0]   mplier_r;

  // Divider working registers.
  logic [AW-1:0]           num_r;
  logic [DW-1:0]           den_r;
  logic [DW-1:0]           rem_r;
  logic [MW-1:0]           quo_r;
  logic [SW-1:0]           step_r;
  logic                    div_occ_r;

  // Result of the current event.
  logic [1:0]              status_r;
  logic [MW-1:0]           occ_r;
  logic [MW-1:0]           wait_r;

  // Output register.
  logic                    out_valid_r;
  logic [31:0]             out_len_r;
  logic [31:0]             out_max_r;
  logic [MW-1:0]           out_occ_r;
  logic [MW-1:0]           out_wait_r;
  logic [1:0]              out_status_r;

  qowm_pkg::alu_req_t      alu_req;
  logic [AW:0]             alu_res;
  logic [63:0]             t_wide;
  logic [COUNT_BITS-1:0]   items_inc;
  logic [COUNT_BITS-1:0]   departures_inc;
  logic [AW-1:0]           next_area;
  logic [COUNT_BITS-1:0]   next_count;
  logic                    div_done;
  logic [MW-1:0]           div_val;
  logic                    qbit;
  logic                    out_load;

  qowm_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign t_wide = 64'(in_chan.event_time);
  assign in_chan.ready = (state_r == S_IDLE);

  assign out_chan.valid            = out_valid_r;
  assign out_chan.queue_length     = out_len_r;
  assign out_chan.max_queue_length = out_max_r;
  assign out_chan.mean_occupancy   = out_occ_r;
  assign out_chan.mean_wait        = out_wait_r;
  assign out_chan.status           = out_status_r;

  // The result register takes a new beat once it is empty or being drained.
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_chan.ready);

  // Saturating counter increments.
  assign items_inc      = (items_r == CNT_MAX) ? items_r : items_r + COUNT_BITS'(1);
  assign departures_inc = (departures_r == CNT_MAX) ? departures_r :
                          departures_r + COUNT_BITS'(1);

  // Operands for the next area after the current one.
  assign next_area  = (idx_r == 2'd0) ? arr_area_r : dep_area_r;
  assign next_count = (idx_r == 2'd0) ? arrivals_r : departures_r;

  // Operand selection for the shared adder/subtractor.
  always_comb begin
    alu_req = '0;
    unique case (state_r)
      S_CHECK: begin
        alu_req.a   = AW'(t_r);
        alu_req.b   = AW'(prev_time_r);
        alu_req.sub = 1'b1;
      end
      S_MUL: begin
        alu_req.a   = acc_r;
        alu_req.b   = mcand_r;
        alu_req.sub = 1'b0;
      end
      S_DIFF: begin
        alu_req.a   = arr_area_r;
        alu_req.b   = dep_area_r;
        alu_req.sub = 1'b1;
      end
      S_DCHK: begin
        alu_req.a   = AW'(num_r[AW-1:AW/2]);
        alu_req.b   = AW'(den_r);
        alu_req.sub = 1'b1;
      end
      S_DIV: begin
        alu_req.a   = AW'({rem_r, num_r[AW-1]});
        alu_req.b   = AW'(den_r);
        alu_req.sub = 1'b1;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // Division finish: zero divisor, quotient too large, or last restoring step.
  always_comb begin
    qbit     = ~alu_res[AW];
    div_done = 1'b0;
    div_val  = '0;
    if (state_r == S_DCHK) begin
      if (den_r == '0) begin
        div_done = 1'b1;
        div_val  = '0;
      end else if (!alu_res[AW]) begin
        div_done = 1'b1;
        div_val  = MEAN_MAX;
      end
    end else if (state_r == S_DIV && step_r == LAST_STEP) begin
      div_done = 1'b1;
      div_val  = {quo_r[MW-2:0], qbit};
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      items_r      <= '0;
      largest_r    <= '0;
      arrivals_r   <= '0;
      departures_r <= '0;
      prev_time_r  <= '0;
      occ_area_r   <= '0;
      arr_area_r   <= '0;
      dep_area_r   <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            op_r     <= in_chan.op;
            t_r      <= t_wide[TIME_BITS-1:0];
            status_r <= qowm_pkg::STAT_OK;
            occ_r    <= '0;
            wait_r   <= '0;
            state_r  <= S_CHECK;
          end
        end

        // Screen the event and start the first area update.
        S_CHECK: begin
          if (alu_res[AW]) begin
            status_r <= qowm_pkg::STAT_BACKWARD;
            state_r  <= S_FIN;
          end else if (op_r == qowm_pkg::OP_NONE) begin
            state_r <= S_FIN;
          end else if (op_r == qowm_pkg::OP_DEPART && items_r == '0) begin
            status_r <= qowm_pkg::STAT_EMPTY;
            state_r  <= S_FIN;
          end else begin
            prev_time_r <= t_r;
            dt_r        <= alu_res[TIME_BITS-1:0];
            idx_r       <= 2'd0;
            acc_r       <= occ_area_r;
            acc_sat_r   <= 1'b0;
            mcand_r     <= AW'(alu_res[TIME_BITS-1:0]);
            mcand_ovf_r <= 1'b0;
            mplier_r    <= items_r;
            state_r     <= S_MUL;
          end
        end

        // Shift-and-add of elapsed time times a count onto an area, saturating.
        S_MUL: begin
          if (mplier_r == '0) begin
            unique case (idx_r)
              2'd0:    occ_area_r <= acc_sat_r ? '1 : acc_r;
              2'd1:    arr_area_r <= acc_sat_r ? '1 : acc_r;
              default: dep_area_r <= acc_sat_r ? '1 : acc_r;
            endcase
            if (idx_r == 2'd2) begin
              state_r <= S_UPD;
            end else begin
              idx_r       <= idx_r + 2'd1;
              acc_r       <= next_area;
              acc_sat_r   <= 1'b0;
              mcand_r     <= AW'(dt_r);
              mcand_ovf_r <= 1'b0;
              mplier_r    <= next_count;
            end
          end else begin
            if (mplier_r[0]) begin
              acc_r <= alu_res[AW-1:0];
              if (alu_res[AW] || mcand_ovf_r) begin
                acc_sat_r <= 1'b1;
              end
            end
            mcand_r     <= {mcand_r[AW-2:0], 1'b0};
            mcand_ovf_r <= mcand_ovf_r | mcand_r[AW-1];
            mplier_r    <= {1'b0, mplier_r[COUNT_BITS-1:1]};
          end
        end

        // Count updates after the areas are settled.
        S_UPD: begin
          unique case (op_r)
            qowm_pkg::OP_ARRIVE: begin
              items_r    <= items_inc;
              arrivals_r <= (arrivals_r == CNT_MAX) ? arrivals_r :
                            arrivals_r + COUNT_BITS'(1);
              if (items_inc > largest_r) begin
                largest_r <= items_inc;
              end
              state_r <= S_FIN;
            end
            qowm_pkg::OP_DEPART: begin
              items_r      <= items_r - COUNT_BITS'(1);
              departures_r <= departures_inc;
              state_r      <= S_FIN;
            end
            qowm_pkg::OP_REPORT: begin
              state_r <= S_DIFF;
            end
            default: begin
              state_r <= S_FIN;
            end
          endcase
        end

        // Wait area, clamped at zero, is divided by arrivals first.
        S_DIFF: begin
          num_r     <= alu_res[AW] ? '0 : alu_res[AW-1:0];
          den_r     <= DW'(arrivals_r);
          div_occ_r <= 1'b0;
          state_r   <= S_DCHK;
        end

        S_DCHK: begin
          if (!div_done) begin
            rem_r   <= DW'(num_r[AW-1:AW/2]);
            num_r   <= {num_r[AW/2-1:0], {(AW/2){1'b0}}};
            step_r  <= '0;
            state_r <= S_DIV;
          end
        end

        // One restoring step per cycle.
        S_DIV: begin
          rem_r  <= qbit ? alu_res[DW-1:0] : {rem_r[DW-2:0], num_r[AW-1]};
          quo_r  <= {quo_r[MW-2:0], qbit};
          if (!div_done) begin
            num_r <= {num_r[AW-2:0], 1'b0};
          end
          step_r <= step_r + SW'(1);
        end

        S_FIN: begin
          if (out_load) begin
            out_len_r    <= 32'(items_r);
            out_max_r    <= 32'(largest_r);
            out_occ_r    <= occ_r;
            out_wait_r   <= wait_r;
            out_status_r <= status_r;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // Hand a finished quotient on to the second division or to the result.
      if (div_done) begin
        if (!div_occ_r) begin
          wait_r    <= div_val;
          num_r     <= occ_area_r;
          den_r     <= DW'(t_r);
          div_occ_r <= 1'b1;
          state_r   <= S_DCHK;
        end else begin
          occ_r   <= div_val;
          state_r <= S_FIN;
        end
      end
    end
  end

endmodule

// ===== rtl/qowm_checker.sv =====
// Port-level assertions for the queue occupancy and wait monitor, bound to the top level.
`timescale 1ns / 1ps

module qowm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] queue_length,
  input logic [31:0] max_queue_length,
  input logic [47:0] mean_occupancy,
  input logic [47:0] mean_wait,
  input logic [1:0]  status
);

  // A stalled result beat holds its length, means and status.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(queue_length) &&
      $stable(mean_occupancy) && $stable(mean_wait) && $stable(status))
    else $error("result beat changed while stalled");

  // The block works on one event at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("event accepted while previous one still in work");

  // The maximum never lags the current length.
  a_max_covers_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> queue_length <= max_queue_length)
    else $error("queue length above recorded maximum");

  // Ignored events carry zero means.
  a_ignored_zero_means: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != qowm_pkg::STAT_OK |-> mean_occupancy == '0 && mean_wait == '0)
    else $error("nonzero mean on an ignored event");

  // Only defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status == qowm_pkg::STAT_OK || status == qowm_pkg::STAT_EMPTY ||
      status == qowm_pkg::STAT_BACKWARD)
    else $error("undefined status code");

endmodule

bind queue_occupancy_wait_monitor_top qowm_checker u_qowm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .queue_length     (out_chan.queue_length),
  .max_queue_length (out_chan.max_queue_length),
  .mean_occupancy   (out_chan.mean_occupancy),
  .mean_wait        (out_chan.mean_wait),
  .status           (out_chan.status)
);
